FILE: hw/rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Q1.15 one and the hue turn and sector, in 1/64 degree.
  localparam logic [15:0] ONE_Q15    = 16'd32768;
  localparam logic [15:0] HUE_TURN   = 16'd23040;
  localparam logic [15:0] HUE_TURN2  = 16'd46080;
  localparam logic [11:0] HUE_SECTOR = 12'd3840;

  // Scale denominator 32768 * 3840 = 15 * 2^23, and half of it for rounding.
  localparam logic [26:0] DENOM      = 27'd125829120;
  localparam logic [26:0] HALF_DENOM = 27'd62914560;
  localparam int unsigned DENOM_SHIFT = 23;

  // ceil(2^24 / 15); exact floor division by 15 for operands below 2^20.
  localparam logic [20:0] RECIP15       = 21'd1118482;
  localparam int unsigned RECIP15_SHIFT = 24;

  localparam logic [2:0] SECT_RED_YEL   = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN   = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN   = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU   = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG   = 3'd4;
  localparam logic [2:0] SECT_MAG_RED   = 3'd5;

  typedef struct packed {
    logic        valid;
    logic [2:0]  sector;
    logic [11:0] rem;
    logic [15:0] s;
    logic [15:0] v;
    logic [15:0] a;
    logic        ok;
    logic        szero;
  } front_t;

endpackage

FILE: hw/rtl/hsv2rgb_front.sv
`timescale 1ns / 1ps

module hsv2rgb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         hue,
  input  logic [15:0]         saturation,
  input  logic [15:0]         brightness,
  input  logic [15:0]         alpha_in,
  output hsv2rgb_pkg::front_t front
);

  typedef struct packed {
    logic        valid;
    logic [14:0] th;
    logic [15:0] s;
    logic [15:0] v;
    logic [15:0] a;
    logic        ok;
    logic        szero;
  } red_t;

  localparam logic [14:0] B1 = 15'(1 * hsv2rgb_pkg::HUE_SECTOR);
  localparam logic [14:0] B2 = 15'(2 * hsv2rgb_pkg::HUE_SECTOR);
  localparam logic [14:0] B3 = 15'(3 * hsv2rgb_pkg::HUE_SECTOR);
  localparam logic [14:0] B4 = 15'(4 * hsv2rgb_pkg::HUE_SECTOR);
  localparam logic [14:0] B5 = 15'(5 * hsv2rgb_pkg::HUE_SECTOR);

  red_t        st1;
  red_t        st1_next;
  logic [15:0] th_wide;
  logic [2:0]  sector_next;
  logic [14:0] base;
  hsv2rgb_pkg::front_t front_next;

  // A 16-bit hue is below three turns, so two compares reduce it.
  always_comb begin
    if (hue >= hsv2rgb_pkg::HUE_TURN2) begin
      th_wide = hue - hsv2rgb_pkg::HUE_TURN2;
    end else if (hue >= hsv2rgb_pkg::HUE_TURN) begin
      th_wide = hue - hsv2rgb_pkg::HUE_TURN;
    end else begin
      th_wide = hue;
    end
    st1_next.valid = in_valid;
    st1_next.th    = th_wide[14:0];
    st1_next.s     = saturation;
    st1_next.v     = brightness;
    st1_next.a     = alpha_in;
    st1_next.ok    = (saturation <= hsv2rgb_pkg::ONE_Q15) &&
                     (brightness <= hsv2rgb_pkg::ONE_Q15) &&
                     (alpha_in <= hsv2rgb_pkg::ONE_Q15);
    st1_next.szero = (saturation == 16'd0);
  end

  always_comb begin
    if (st1.th >= B5) begin
      sector_next = hsv2rgb_pkg::SECT_MAG_RED;
      base        = B5;
    end else if (st1.th >= B4) begin
      sector_next = hsv2rgb_pkg::SECT_BLU_MAG;
      base        = B4;
    end else if (st1.th >= B3) begin
      sector_next = hsv2rgb_pkg::SECT_CYN_BLU;
      base        = B3;
    end else if (st1.th >= B2) begin
      sector_next = hsv2rgb_pkg::SECT_GRN_CYN;
      base        = B2;
    end else if (st1.th >= B1) begin
      sector_next = hsv2rgb_pkg::SECT_YEL_GRN;
      base        = B1;
    end else begin
      sector_next = hsv2rgb_pkg::SECT_RED_YEL;
      base        = 15'd0;
    end
    front_next.valid  = st1.valid;
    front_next.sector = sector_next;
    front_next.rem    = 12'(st1.th - base);
    front_next.s      = st1.s;
    front_next.v      = st1.v;
    front_next.a      = st1.a;
    front_next.ok     = st1.ok;
    front_next.szero  = st1.szero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.valid   <= 1'b0;
      front.valid <= 1'b0;
    end else if (en) begin
      st1   <= st1_next;
      front <= front_next;
    end
  end

endmodule

FILE: hw/rtl/hsv2rgb_scale.sv
`timescale 1ns / 1ps

// Computes round(v * (1 - s*w/3840)) in Q1.15 over three register stages.
module hsv2rgb_scale (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] s,
  input  logic [15:0] v,
  input  logic [11:0] w,
  output logic [15:0] q
);

  logic [27:0] sw;
  logic [26:0] diff;
  logic [26:0] diff_next;
  logic [15:0] v_d;
  logic [42:0] num;
  logic [42:0] num_next;
  logic [42:0] rnd;
  logic [19:0] q1;
  logic [40:0] prod;
  logic [40:0] prod_next;

  assign sw        = 28'(s) * 28'(w);
  assign diff_next = (sw <= 28'(hsv2rgb_pkg::DENOM)) ?
                     27'(28'(hsv2rgb_pkg::DENOM) - sw) : 27'd0;
  assign num_next  = 43'(v_d) * 43'(diff);

  // The denominator is 15 * 2^23: shift first, then divide by 15 by reciprocal.
  assign rnd       = num + 43'(hsv2rgb_pkg::HALF_DENOM);
  assign q1        = rnd[42:hsv2rgb_pkg::DENOM_SHIFT];
  assign prod_next = 41'(q1) * 41'(hsv2rgb_pkg::RECIP15);
  assign q         = prod[hsv2rgb_pkg::RECIP15_SHIFT +: 16];

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_next;
      v_d  <= v;
      num  <= num_next;
      prod <= prod_next;
    end
  end

endmodule

FILE: hw/rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

// HSV plus alpha to RGBA converter. Hue is in 1/64 degree and wraps at 360
// degrees; saturation, brightness and alpha are Q1.15 with 32768 as 1.0. The
// block takes one colour per cycle while the output is not stalled, and each
// result goes through: two stages reduce the hue and find the sector, three
// stages form each scaled term (s*w, v*(1-s*w), rounding divide), and one
// output register routes the terms. A stall on the output freezes the whole
// pipeline, so in_stall is high exactly while a held result is stalled. An
// operand above 1.0 gives zero colour fields and valid_res low.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] hue,
  input  logic [15:0] saturation,
  input  logic [15:0] brightness,
  input  logic [15:0] alpha_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue,
  output logic [15:0] alpha_out,
  output logic        valid_res
);

  localparam int unsigned SCALE_DEPTH = 3;

  typedef struct packed {
    logic        valid;
    logic [2:0]  sector;
    logic [15:0] v;
    logic [15:0] a;
    logic        ok;
    logic        szero;
  } side_t;

  logic                en;
  hsv2rgb_pkg::front_t front;
  logic [11:0]         w_n;
  logic [11:0]         w_k;
  logic [15:0]         term_m;
  logic [15:0]         term_n;
  logic [15:0]         term_k;
  side_t               side [SCALE_DEPTH];
  side_t               side_in;
  side_t               last;
  logic [15:0]         red_next;
  logic [15:0]         green_next;
  logic [15:0]         blue_next;
  logic [15:0]         alpha_next;
  logic                valid_res_next;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  hsv2rgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .front      (front)
  );

  assign w_n = front.rem;
  assign w_k = hsv2rgb_pkg::HUE_SECTOR - front.rem;

  hsv2rgb_scale u_scale_m (
    .clk (clk),
    .en  (en),
    .s   (front.s),
    .v   (front.v),
    .w   (hsv2rgb_pkg::HUE_SECTOR),
    .q   (term_m)
  );

  hsv2rgb_scale u_scale_n (
    .clk (clk),
    .en  (en),
    .s   (front.s),
    .v   (front.v),
    .w   (w_n),
    .q   (term_n)
  );

  hsv2rgb_scale u_scale_k (
    .clk (clk),
    .en  (en),
    .s   (front.s),
    .v   (front.v),
    .w   (w_k),
    .q   (term_k)
  );

  // Sector, brightness, alpha and flags travel beside the scale stages.
  assign side_in.valid  = front.valid;
  assign side_in.sector = front.sector;
  assign side_in.v      = front.v;
  assign side_in.a      = front.a;
  assign side_in.ok     = front.ok;
  assign side_in.szero  = front.szero;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SCALE_DEPTH; i++) begin
        side[i].valid <= 1'b0;
      end
    end else if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < SCALE_DEPTH; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign last = side[SCALE_DEPTH-1];

  always_comb begin
    case (last.sector)
      hsv2rgb_pkg::SECT_RED_YEL: begin
        red_next = last.v;  green_next = term_k; blue_next = term_m;
      end
      hsv2rgb_pkg::SECT_YEL_GRN: begin
        red_next = term_n;  green_next = last.v; blue_next = term_m;
      end
      hsv2rgb_pkg::SECT_GRN_CYN: begin
        red_next = term_m;  green_next = last.v; blue_next = term_k;
      end
      hsv2rgb_pkg::SECT_CYN_BLU: begin
        red_next = term_m;  green_next = term_n; blue_next = last.v;
      end
      hsv2rgb_pkg::SECT_BLU_MAG: begin
        red_next = term_k;  green_next = term_m; blue_next = last.v;
      end
      default: begin
        red_next = last.v;  green_next = term_m; blue_next = term_n;
      end
    endcase
    alpha_next     = last.a;
    valid_res_next = last.ok;
    if (!last.ok) begin
      red_next   = 16'd0;
      green_next = 16'd0;
      blue_next  = 16'd0;
      alpha_next = 16'd0;
    end else if (last.szero) begin
      red_next   = last.v;
      green_next = last.v;
      blue_next  = last.v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red       <= red_next;
      green     <= green_next;
      blue      <= blue_next;
      alpha_out <= alpha_next;
      valid_res <= valid_res_next;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |->
      red == 16'd0 && green == 16'd0 && blue == 16'd0 && alpha_out == 16'd0)
    else $error("invalid result carries nonzero fields");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |->
      red <= hsv2rgb_pkg::ONE_Q15 && green <= hsv2rgb_pkg::ONE_Q15 &&
      blue <= hsv2rgb_pkg::ONE_Q15)
    else $error("color component above one");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("pipeline stalls input with no result waiting");

endmodule

FILE: sim/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

  localparam int unsigned IDLE_PCT    = 14;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 24;
  localparam int unsigned RAND_ITEMS  = 650;
  // Transfer counts between which neither side idles.
  localparam int unsigned CALM_LO     = 250;
  localparam int unsigned CALM_HI     = 400;

  typedef struct {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] bri;
    logic [15:0] alpha;
    logic        drain_first;
  } colour_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        ok;
  } rgba_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] hue = '0;
  logic [15:0] saturation = '0;
  logic [15:0] brightness = '0;
  logic [15:0] alpha_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] alpha_out;
  logic        valid_res;

  colour_t     colours_to_send[$];
  rgba_t       rgba_expect[$];
  int unsigned sent_total = 0;
  int unsigned got_total = 0;
  int unsigned mismatches = 0;
  int unsigned idle_run = 0;
  int unsigned n_grey = 0;
  int unsigned n_bad_operand = 0;
  int unsigned n_drains = 0;

  hsv_to_rgb_converter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_out  (alpha_out),
    .valid_res  (valid_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // v * (1 - s*w/3840), rounded to the nearest Q1.15 step with halves up.
  function automatic logic [15:0] scaled_term(logic [15:0] v, logic [15:0] s,
                                              logic [11:0] w);
    logic [63:0] denom;
    logic [63:0] sw;
    logic [63:0] diff;
    logic [63:0] num;
    denom = 64'(hsv2rgb_pkg::ONE_Q15) * 64'(hsv2rgb_pkg::HUE_SECTOR);
    sw    = 64'(s) * 64'(w);
    diff  = (sw <= denom) ? denom - sw : 64'd0;
    num   = 64'(v) * diff;
    return 16'((num + denom / 2) / denom);
  endfunction

  function automatic rgba_t hsv_rgba(logic [15:0] h, logic [15:0] s, logic [15:0] v,
                                     logic [15:0] a);
    rgba_t       res;
    logic [15:0] turn_pos;
    logic [2:0]  sector;
    logic [11:0] frac;
    logic [15:0] m;
    logic [15:0] n;
    logic [15:0] k;
    res = '{red: '0, green: '0, blue: '0, alpha: '0, ok: 1'b0};
    if (s > hsv2rgb_pkg::ONE_Q15 || v > hsv2rgb_pkg::ONE_Q15 ||
        a > hsv2rgb_pkg::ONE_Q15) return res;
    res.ok    = 1'b1;
    res.alpha = a;
    if (s == 16'd0) begin
      res.red   = v;
      res.green = v;
      res.blue  = v;
      return res;
    end
    turn_pos = h % hsv2rgb_pkg::HUE_TURN;
    sector   = 3'(turn_pos / 16'(hsv2rgb_pkg::HUE_SECTOR));
    frac     = 12'(turn_pos % 16'(hsv2rgb_pkg::HUE_SECTOR));
    m = scaled_term(v, s, hsv2rgb_pkg::HUE_SECTOR);
    n = scaled_term(v, s, frac);
    k = scaled_term(v, s, hsv2rgb_pkg::HUE_SECTOR - frac);
    case (sector)
      hsv2rgb_pkg::SECT_RED_YEL: begin res.red = v; res.green = k; res.blue = m; end
      hsv2rgb_pkg::SECT_YEL_GRN: begin res.red = n; res.green = v; res.blue = m; end
      hsv2rgb_pkg::SECT_GRN_CYN: begin res.red = m; res.green = v; res.blue = k; end
      hsv2rgb_pkg::SECT_CYN_BLU: begin res.red = m; res.green = n; res.blue = v; end
      hsv2rgb_pkg::SECT_BLU_MAG: begin res.red = k; res.green = m; res.blue = v; end
      default:                   begin res.red = v; res.green = m; res.blue = n; end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_colour(logic [15:0] h, logic [15:0] s, logic [15:0] v,
                              logic [15:0] a, logic drain_first);
    colour_t item;
    item = '{hue: h, sat: s, bri: v, alpha: a, drain_first: drain_first};
    colours_to_send.insert(colours_to_send.size(), item);
    if (s > hsv2rgb_pkg::ONE_Q15 || v > hsv2rgb_pkg::ONE_Q15 ||
        a > hsv2rgb_pkg::ONE_Q15) n_bad_operand++;
    else if (s == 16'd0) n_grey++;
    if (drain_first) n_drains++;
  endtask

  function automatic logic [15:0] q15_operand(bit allow_over);
    int unsigned pick;
    pick = $urandom_range(99);
    if (allow_over && pick < 12) return 16'($urandom_range(65535));
    if (pick < 17) return hsv2rgb_pkg::ONE_Q15;
    if (pick < 22) return 16'd0;
    return 16'($urandom_range(32768));
  endfunction

  // Driver: a new color is offered only once the previous one has been taken.
  always @(posedge clk) begin
    logic    took;
    logic    go;
    colour_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        rgba_expect.insert(rgba_expect.size(),
                           hsv_rgba(hue, saturation, brightness, alpha_in));
        sent_total <= sent_total + 1;
      end
      if (!(in_valid && !took)) begin
        go = 1'b0;
        if (colours_to_send.size() != 0) begin
          if (colours_to_send[0].drain_first && (sent_total + took != got_total))
            go = 1'b0;
          else if ((sent_total >= CALM_LO && sent_total < CALM_HI) ||
                   $urandom_range(99) >= IDLE_PCT)
            go = 1'b1;
        end
        if (go) begin
          nxt = colours_to_send.pop_front();
          in_valid   <= 1'b1;
          hue        <= nxt.hue;
          saturation <= nxt.sat;
          brightness <= nxt.bri;
          alpha_in   <= nxt.alpha;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    rgba_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_total <= got_total + 1;
        if (rgba_expect.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: rgba %0d %0d %0d %0d ok %0b",
                                    red, green, blue, alpha_out, valid_res));
        end else begin
          want = rgba_expect.pop_front();
          if (red !== want.red || green !== want.green || blue !== want.blue ||
              alpha_out !== want.alpha || valid_res !== want.ok)
            report_mismatch($sformatf(
              "result %0d: got rgba %0d %0d %0d %0d ok %0b, want %0d %0d %0d %0d ok %0b",
              got_total, red, green, blue, alpha_out, valid_res,
              want.red, want.green, want.blue, want.alpha, want.ok));
        end
      end
      if (got_total >= CALM_LO && got_total < CALM_HI)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("hsv_to_rgb_converter regression: fail");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    logic [15:0] h;
    // Gray, including wrapped and extreme hues.
    queue_colour(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_colour(16'd65535, 16'd0, hsv2rgb_pkg::ONE_Q15, hsv2rgb_pkg::ONE_Q15, 1'b0);
    queue_colour(16'd9000, 16'd0, 16'd12345, 16'd777, 1'b0);
    // Full saturation and value at each sector start.
    for (int i = 0; i < 6; i++)
      queue_colour(16'(i * 3840), hsv2rgb_pkg::ONE_Q15, hsv2rgb_pkg::ONE_Q15,
                   hsv2rgb_pkg::ONE_Q15, 1'b0);
    // Middle and last step of sectors, the wrap point and beyond a full turn.
    queue_colour(16'd1920, hsv2rgb_pkg::ONE_Q15, hsv2rgb_pkg::ONE_Q15, 16'd16384, 1'b0);
    queue_colour(16'd3839, 16'd20000, 16'd30000, 16'd1, 1'b0);
    queue_colour(16'd23039, hsv2rgb_pkg::ONE_Q15, hsv2rgb_pkg::ONE_Q15, 16'd0, 1'b0);
    queue_colour(16'd23040, hsv2rgb_pkg::ONE_Q15, hsv2rgb_pkg::ONE_Q15,
                 hsv2rgb_pkg::ONE_Q15, 1'b0);
    queue_colour(16'd46080, 16'd1, hsv2rgb_pkg::ONE_Q15, hsv2rgb_pkg::ONE_Q15, 1'b0);
    queue_colour(16'd65535, hsv2rgb_pkg::ONE_Q15, hsv2rgb_pkg::ONE_Q15,
                 hsv2rgb_pkg::ONE_Q15, 1'b0);
    queue_colour(16'd13000, 16'd1, 16'd1, 16'd1, 1'b0);
    // Operands above one, one at a time and all together.
    queue_colour(16'd5000, 16'd32769, 16'd20000, 16'd20000, 1'b0);
    queue_colour(16'd5000, 16'd20000, 16'd32769, 16'd20000, 1'b0);
    queue_colour(16'd5000, 16'd20000, 16'd20000, 16'd32769, 1'b0);
    queue_colour(16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0);
    queue_colour(16'd0, 16'd0, 16'd65535, 16'd0, 1'b0);
    // Zero value with full saturation.
    queue_colour(16'd17000, hsv2rgb_pkg::ONE_Q15, 16'd0, hsv2rgb_pkg::ONE_Q15, 1'b1);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      h = 16'($urandom_range(65535));
      if ($urandom_range(9) == 0) h = 16'(($urandom_range(5) * 3840 + $urandom_range(1)) % 65536);
      queue_colour(h, q15_operand(1'b1), q15_operand(1'b1), q15_operand(1'b1),
                   (i == 180 || i == 470));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (colours_to_send.size() != 0 || in_valid || rgba_expect.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rgba_expect.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", rgba_expect.size()));

    $display("covered %0d colors: %0d gray, %0d with an operand above one, %0d drains",
             sent_total, n_grey, n_bad_operand, n_drains);
    $display("checked %0d results, %0d mismatches", got_total, mismatches);
    if (mismatches == 0) begin
      $display("hsv_to_rgb_converter regression: pass");
    end else begin
      $display("hsv_to_rgb_converter regression: fail");
    end
    $finish;
  end

endmodule
